@@ sv/lmd_pkg.sv @@
// package for the 3x3 local-maximum detector
// constants, report codes, register indexes and queue status shared by all files
// no dependencies
`default_nettype none

package lmd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;
  localparam int ROW_BITS     = 10;
  localparam int COL_BITS     = 10;
  localparam int TOTAL_BITS   = 21;

  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // decision queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // result slots of one pixel, in emission order
  localparam int NUM_SLOTS = 5;
  localparam int SLOT_UL   = 0;  // centre (r-1, c-1)
  localparam int SLOT_UR   = 1;  // centre (r-1, c), last column
  localparam int SLOT_LL   = 2;  // centre (r, c-1), last row
  localparam int SLOT_LR   = 3;  // centre (r, c), last pixel
  localparam int SLOT_END  = 4;  // frame end

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PEAK = 1'b0,
    KIND_END  = 1'b1
  } report_kind_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] free;
    logic                 empty;
  } q_stat_t;

  // zero counts as one, oversize saturates to the maximum
  function automatic logic [31:0] clamp_size(logic [CFG_BITS-1:0] v, int maxv);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return 32'd1;
    end
    if (v32 > 32'(maxv)) begin
      return 32'(maxv);
    end
    return v32;
  endfunction

endpackage

`default_nettype wire

@@ sv/lmd_ifs.sv @@
// channel interfaces of the 3x3 local-maximum detector
// pixel input, report output and configuration write; depends on lmd_pkg
`default_nettype none

interface lmd_pix_if import lmd_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lmd_rpt_if import lmd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  report_kind;
  logic [ROW_BITS-1:0]   peak_row;
  logic [COL_BITS-1:0]   peak_col;
  logic [TOTAL_BITS-1:0] peak_total;
  logic                  last;

  modport source (output valid, output report_kind, output peak_row, output peak_col,
                  output peak_total, output last, input ready);
  modport sink   (input valid, input report_kind, input peak_row, input peak_col,
                  input peak_total, input last, output ready);
endinterface

interface lmd_cfg_if import lmd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0]     wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

@@ sv/lmd_front.sv @@
// front part: size registers, raster position, line store, window and peak decisions
// depends on lmd_pkg and lmd_ifs
`default_nettype none

module lmd_front import lmd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int CW         = 10,
  parameter int RW         = 10,
  parameter int EW         = RW + CW + NUM_SLOTS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lmd_pix_if.sink       in_px,
  lmd_cfg_if.sink       cfg_wr,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output logic [EW-1:0] push_data
);

  localparam int PB = PIXEL_BITS;

  typedef logic signed [PB-1:0] win_t [3][3];

  logic [CFG_BITS-1:0] frame_width_r, frame_height_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [31:0]         w32, h32, c32, r32;
  logic [CW-1:0]       c_cur;
  logic [RW-1:0]       r_cur;
  logic                lastc, lastr, accept;

  // line store entry: previous row in the upper half, older row in the lower
  logic [2*PB-1:0]     mem_r [MAX_WIDTH];
  logic [2*PB-1:0]     rd_r, byp_data_r, rd_eff;
  logic                byp_r;

  logic                s1_v_r, s1_lastc_r, s1_lastr_r;
  logic signed [PB-1:0] s1_pix_r;
  logic [CW-1:0]       s1_c_r;
  logic [RW-1:0]       s1_r_r;

  win_t                win_r;
  logic                s2_v_r, s2_lastc_r, s2_lastr_r;
  logic [CW-1:0]       s2_c_r;
  logic [RW-1:0]       s2_r_r;
  logic                rge1, rge2, cge1, cge2;
  logic [NUM_SLOTS-1:0] mask;

  // strict greater than every neighbour that lies inside the frame
  function automatic logic is_peak(win_t win, int wr, int wc,
                                   logic up, logic dn, logic lf, logic rt);
    logic ok, row_ok, col_ok;
    int   xr, xc;
    ok = 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        row_ok = (dr < 0) ? up : ((dr > 0) ? dn : 1'b1);
        col_ok = (dc < 0) ? lf : ((dc > 0) ? rt : 1'b1);
        xr = (wr + dr > 2) ? 2 : wr + dr;
        xc = (wc + dc > 2) ? 2 : wc + dc;
        if (!(dr == 0 && dc == 0) && row_ok && col_ok) begin
          if (!(win[wr][wc] > win[xr][xc])) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

  // configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_BITS'(1);
      frame_height_r <= CFG_BITS'(1);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.reg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wr.wr_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wr.wr_data;
        default: ;
      endcase
    end
  end

  // position, saturated to the current size
  always_comb begin
    w32   = clamp_size(frame_width_r, MAX_WIDTH);
    h32   = clamp_size(frame_height_r, MAX_HEIGHT);
    c32   = (32'(col_r) >= w32) ? w32 - 32'd1 : 32'(col_r);
    r32   = (32'(row_r) >= h32) ? h32 - 32'd1 : 32'(row_r);
    c_cur = c32[CW-1:0];
    r_cur = r32[RW-1:0];
    lastc = (c32 == w32 - 32'd1);
    lastr = (r32 == h32 - 32'd1);
    col_nxt = lastc ? '0 : CW'(c32 + 32'd1);
    row_nxt = r_cur;
    if (lastc) begin
      row_nxt = lastr ? '0 : RW'(r32 + 32'd1);
    end
  end

  // two items may still be on their way to the queue
  assign in_px.ready = (32'(q_stat.free) > 32'(s1_v_r) + 32'(s2_v_r));
  assign accept      = in_px.valid && in_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      byp_r  <= s1_v_r && (s1_c_r == c_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_px.pixel_value;
      s1_c_r     <= c_cur;
      s1_r_r     <= r_cur;
      s1_lastc_r <= lastc;
      s1_lastr_r <= lastr;
    end
  end

  // line store, read at the accepted column, written back in the next cycle
  assign rd_eff = byp_r ? byp_data_r : rd_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      mem_r[s1_c_r] <= {s1_pix_r, rd_eff[2*PB-1:PB]};
    end
    rd_r       <= mem_r[c_cur];
    byp_data_r <= {s1_pix_r, rd_eff[2*PB-1:PB]};
  end

  // window shift with the new column
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= rd_eff[PB-1:0];
      win_r[1][2] <= rd_eff[2*PB-1:PB];
      win_r[2][2] <= s1_pix_r;
      s2_c_r      <= s1_c_r;
      s2_r_r      <= s1_r_r;
      s2_lastc_r  <= s1_lastc_r;
      s2_lastr_r  <= s1_lastr_r;
    end
  end

  // decisions for the up to four centres completed by this pixel
  always_comb begin
    rge1 = (32'(s2_r_r) >= 32'd1);
    rge2 = (32'(s2_r_r) >= 32'd2);
    cge1 = (32'(s2_c_r) >= 32'd1);
    cge2 = (32'(s2_c_r) >= 32'd2);
    mask = '0;
    mask[SLOT_UL]  = rge1 && cge1 && is_peak(win_r, 1, 1, rge2, 1'b1, cge2, 1'b1);
    mask[SLOT_UR]  = rge1 && s2_lastc_r && is_peak(win_r, 1, 2, rge2, 1'b1, cge1, 1'b0);
    mask[SLOT_LL]  = s2_lastr_r && cge1 && is_peak(win_r, 2, 1, rge1, 1'b0, cge2, 1'b1);
    mask[SLOT_LR]  = s2_lastr_r && s2_lastc_r &&
                     is_peak(win_r, 2, 2, rge1, 1'b0, cge1, 1'b0);
    mask[SLOT_END] = s2_lastr_r && s2_lastc_r;
  end

  assign push      = s2_v_r && (mask != '0);
  assign push_data = {s2_r_r, s2_c_r, mask};

endmodule

`default_nettype wire

@@ sv/lmd_queue.sv @@
// decision queue between front and back parts
// small register file with head read; depends on lmd_pkg
`default_nettype none

module lmd_queue import lmd_pkg::*; #(
  parameter int EW = 25
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [EW-1:0] push_data,
  input  wire logic          pop,
  output logic [EW-1:0]      head_data,
  output q_stat_t            q_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [EW-1:0]        ent_r [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : PW'(32'(p) + 32'd1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data    = ent_r[rd_ptr_r];
  assign q_stat.free  = QCNT_BITS'(QUEUE_DEPTH) - cnt_r;
  assign q_stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

@@ sv/lmd_back.sv @@
// back part: walks the results of each queued decision, keeps the peak count
// and holds the output register; depends on lmd_pkg and lmd_ifs
`default_nettype none

module lmd_back import lmd_pkg::*; #(
  parameter int CW = 10,
  parameter int RW = 10,
  parameter int EW = RW + CW + NUM_SLOTS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [EW-1:0] head_data,
  input  wire q_stat_t       q_stat,
  output logic               pop,
  lmd_rpt_if.source          out_rpt
);

  logic [RW-1:0]         h_row;
  logic [CW-1:0]         h_col;
  logic [NUM_SLOTS-1:0]  h_mask, done_r, pend, pick, rest;
  logic                  adv;
  logic [31:0]           row32, col32;
  logic [TOTAL_BITS-1:0] cnt_r, cnt_inc;

  logic                  out_valid_r, kind_r, last_r;
  logic [ROW_BITS-1:0]   row_r;
  logic [COL_BITS-1:0]   col_r;
  logic [TOTAL_BITS-1:0] total_r;

  assign {h_row, h_col, h_mask} = head_data;

  always_comb begin
    pend    = h_mask & ~done_r;
    pick    = pend & (~pend + NUM_SLOTS'(1));
    rest    = pend & ~pick;
    adv     = !q_stat.empty && (!out_valid_r || out_rpt.ready);
    cnt_inc = (cnt_r == TOTAL_MAX) ? cnt_r : cnt_r + TOTAL_BITS'(1);
    row32   = 32'd0;
    col32   = 32'd0;
    if (pick[SLOT_UL] || pick[SLOT_UR]) begin
      row32 = 32'(h_row) - 32'd1;
    end else if (pick[SLOT_LL] || pick[SLOT_LR]) begin
      row32 = 32'(h_row);
    end
    if (pick[SLOT_UL] || pick[SLOT_LL]) begin
      col32 = 32'(h_col) - 32'd1;
    end else if (pick[SLOT_UR] || pick[SLOT_LR]) begin
      col32 = 32'(h_col);
    end
  end

  assign pop = adv && (rest == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
      cnt_r       <= '0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      done_r      <= (rest == '0) ? '0 : (done_r | pick);
      cnt_r       <= pick[SLOT_END] ? '0 : cnt_inc;
    end else if (out_rpt.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r  <= pick[SLOT_END] ? KIND_END : KIND_PEAK;
      row_r   <= row32[ROW_BITS-1:0];
      col_r   <= col32[COL_BITS-1:0];
      total_r <= pick[SLOT_END] ? cnt_r : cnt_inc;
      last_r  <= (rest == '0);
    end
  end

  assign out_rpt.valid       = out_valid_r;
  assign out_rpt.report_kind = kind_r;
  assign out_rpt.peak_row    = row_r;
  assign out_rpt.peak_col    = col_r;
  assign out_rpt.peak_total  = total_r;
  assign out_rpt.last        = last_r;

endmodule

`default_nettype wire

@@ sv/local_maximum_3x3_detector.sv @@
// first report of a pixel reaches the output register through front stages s1, s2 and the decision queue
// throughput: one pixel per cycle while the queue has room; one report per cycle while the sink is
//   ready, set by the back sequencer and absorbed by a 4-entry queue (row ends give up to 2, frame end up to 5)
// reset: rst_n synchronous, clears position, counter, queue and sizes (width = height = 1);
//   the line store is not cleared and needs no clearing pass
// depends on lmd_pkg, lmd_ifs, lmd_front, lmd_queue, lmd_back
`default_nettype none

module local_maximum_3x3_detector import lmd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  lmd_pix_if.sink   in_px,
  lmd_rpt_if.source out_rpt,
  lmd_cfg_if.sink   cfg_wr
);

  // column and row position widths
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // queue entry: row, column and one bit per result slot
  localparam int EW = RW + CW + NUM_SLOTS;

  q_stat_t       q_stat;
  logic          push, pop;
  logic [EW-1:0] push_data, head_data;

  // front: takes a pixel transfer every cycle while the queue has room for
  // everything still in flight, runs line store and window, decides centres
  lmd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS),
    .CW         (CW),
    .RW         (RW),
    .EW         (EW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px),
    .cfg_wr    (cfg_wr),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // queue: only pixels that cause at least one report are stored
  lmd_queue #(
    .EW (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .q_stat    (q_stat)
  );

  // back: one report per cycle into the output register while the sink is ready; the queue lets the
  // sink stall without blocking the front until it fills
  lmd_back #(
    .CW (CW),
    .RW (RW),
    .EW (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_data (head_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_rpt   (out_rpt)
  );

endmodule

`default_nettype wire

@@ sv/lmd_checker.sv @@
// port-level checks for the 3x3 local-maximum detector, bound to the top level
// depends on lmd_pkg and local_maximum_3x3_detector
`default_nettype none

module lmd_checker import lmd_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_kind,
  input wire logic [ROW_BITS-1:0]   out_row,
  input wire logic [COL_BITS-1:0]   out_col,
  input wire logic [TOTAL_BITS-1:0] out_total,
  input wire logic                  out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_kind, out_row, out_col, out_total, out_last}))
    else $error("report changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid after reset");

  a_end_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_END) |-> out_last && (out_row == '0) && (out_col == '0))
    else $error("frame end report malformed");

  a_peak_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PEAK) |-> (out_total != '0))
    else $error("peak report with zero total");

endmodule

bind local_maximum_3x3_detector lmd_checker u_lmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rpt.valid),
  .out_ready (out_rpt.ready),
  .out_kind  (out_rpt.report_kind),
  .out_row   (out_rpt.peak_row),
  .out_col   (out_rpt.peak_col),
  .out_total (out_rpt.peak_total),
  .out_last  (out_rpt.last)
);

`default_nettype wire

@@ tb/sv/tb_local_maximum_3x3_detector.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the 3x3 local-maximum detector: random frames of signed pixels,
// a cycle-free peak predictor, an in-order report scoreboard, random idling at input and output
// depends on lmd_pkg, lmd_ifs and local_maximum_3x3_detector

module tb_local_maximum_3x3_detector;
  import lmd_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = MAX_HEIGHT_DEF;
  localparam int PIX_W         = PIXEL_BITS_DEF;
  localparam int RANDOM_PIXELS = 190;
  localparam int SETTLE_CYCLES = 10;    // well past the report latency
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer anywhere
  localparam int SHOWN_ERRORS  = 10;

  typedef logic signed [PIX_W-1:0] pixel_t;

  // how pixel values of one frame are drawn
  typedef enum int {
    PIX_WIDE,   // full 16-bit range
    PIX_TIES,   // -2..2, lots of equal neighbours
    PIX_EDGES   // extremes, 0 and -1 mixed with wide values
  } pix_mix_t;

  typedef struct packed {
    report_kind_t          kind;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic [TOTAL_BITS-1:0] total;
    logic                  last;
  } report_t;

  logic clk;
  logic rst_n;

  lmd_pix_if px_if ();
  lmd_rpt_if rpt_if ();
  lmd_cfg_if cfg_if ();

  local_maximum_3x3_detector dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (px_if),
    .out_rpt (rpt_if),
    .cfg_wr  (cfg_if)
  );

  // pixels waiting to be offered, and the reports the predictor says must come back
  pixel_t  pixel_feed [$];
  report_t reports_due [$];

  // predictor state: two line stores, the 3x3 window, raster position and peak count
  pixel_t                line_older [MAX_W];
  pixel_t                line_prev  [MAX_W];
  pixel_t                win_px [3][3];
  int                    col_pos;
  int                    row_pos;
  logic [TOTAL_BITS-1:0] peaks_in_frame;
  logic [CFG_BITS-1:0]   width_reg;
  logic [CFG_BITS-1:0]   height_reg;

  int mismatch_count;
  int quiet_cycles;

  // handshake pacing; on the pixel side shared between the posedge and negedge halves
  bit px_taken;
  int feed_gap;
  int feed_calm;
  int sink_stall;
  int sink_calm;
  int sink_hold;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // zero means one column/row, anything above the maximum saturates
  function automatic int frame_extent(logic [CFG_BITS-1:0] v, int maxv);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  // pixels still needed to close the current frame at the current sizes
  function automatic int pixels_to_frame_end();
    int w, h, c, r;
    w = frame_extent(width_reg, MAX_W);
    h = frame_extent(height_reg, MAX_H);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    return (h - 1 - r) * w + (w - c);
  endfunction

  // centre at window (wr,wc), frame (gr,gc): strict peak over every neighbour inside the frame
  function automatic void judge_centre(int wr, int wc, int gr, int gc, int w, int h);
    report_t rep;
    int      nr, nc, xr, xc;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = gr + dr;
        nc = gc + dc;
        xr = wr + dr;
        xc = wc + dc;
        if (dr == 0 && dc == 0) continue;
        if (nr < 0 || nr >= h || nc < 0 || nc >= w) continue;  // outside the frame: passed
        if (xr < 0 || xr > 2 || xc < 0 || xc > 2) continue;
        if (!(win_px[wr][wc] > win_px[xr][xc])) return;
      end
    end
    if (peaks_in_frame != TOTAL_MAX) begin
      peaks_in_frame++;
    end
    rep.kind  = KIND_PEAK;
    rep.row   = ROW_BITS'(gr);
    rep.col   = COL_BITS'(gc);
    rep.total = peaks_in_frame;
    rep.last  = 1'b0;
    reports_due.push_back(rep);
  endfunction

  // one accepted pixel: shift the window, update the line stores, decide the centres it closes
  function automatic void detect_peaks(pixel_t pix);
    int      w, h, r, c, first_new;
    bit      last_c, last_r;
    report_t rep;
    w = frame_extent(width_reg, MAX_W);
    h = frame_extent(height_reg, MAX_H);
    first_new = reports_due.size();
    // a size that shrank under the current position pulls it back to the last column/row
    if (col_pos >= w) col_pos = w - 1;
    if (row_pos >= h) row_pos = h - 1;
    r = row_pos;
    c = col_pos;
    last_c = (c == w - 1);
    last_r = (r == h - 1);

    for (int k = 0; k < 3; k++) begin
      win_px[k][0] = win_px[k][1];
      win_px[k][1] = win_px[k][2];
    end
    win_px[0][2] = line_older[c];
    win_px[1][2] = line_prev[c];
    win_px[2][2] = pix;
    line_older[c] = line_prev[c];
    line_prev[c]  = pix;

    // decision order: upper left, upper right at row end, lower left on last row, last pixel
    if (r >= 1 && c >= 1) judge_centre(1, 1, r - 1, c - 1, w, h);
    if (r >= 1 && last_c) judge_centre(1, 2, r - 1, c, w, h);
    if (last_r && c >= 1) judge_centre(2, 1, r, c - 1, w, h);
    if (last_r && last_c) begin
      judge_centre(2, 2, r, c, w, h);
      rep.kind  = KIND_END;
      rep.row   = '0;
      rep.col   = '0;
      rep.total = peaks_in_frame;
      rep.last  = 1'b0;
      reports_due.push_back(rep);
    end

    if (last_c) begin
      col_pos = 0;
      if (last_r) begin
        row_pos        = 0;
        peaks_in_frame = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end

    // flag the final report of this pixel
    if (reports_due.size() > first_new) begin
      rep = reports_due.pop_back();
      rep.last = 1'b1;
      reports_due.push_back(rep);
    end
  endfunction

  initial begin
    foreach (line_older[i]) begin
      line_older[i] = '0;
      line_prev[i]  = '0;
    end
    foreach (win_px[i, j]) begin
      win_px[i][j] = '0;
    end
    col_pos        = 0;
    row_pos        = 0;
    peaks_in_frame = '0;
    width_reg      = CFG_BITS'(1);
    height_reg     = CFG_BITS'(1);
  end

  // ---------------------------------------------------------------------------
  // pacing helpers
  // ---------------------------------------------------------------------------

  // mostly no gap, some short, a few long; now and then a calm stretch with none at all
  function automatic int next_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    case ($urandom_range(0, 19))
      0: begin
        calm_left = $urandom_range(10, 40);
        return 0;
      end
      1:                return $urandom_range(8, 40);
      2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
      default:          return 0;
    endcase
  endfunction

  function automatic pixel_t make_pixel(pix_mix_t mix);
    case (mix)
      PIX_TIES: return PIX_W'(int'($urandom_range(0, 4)) - 2);
      PIX_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(PIX_W-1){1'b0}}};
          1:       return {1'b0, {(PIX_W-1){1'b1}}};
          2:       return '0;
          3:       return '1;
          default: return PIX_W'($urandom_range(0, 65535));
        endcase
      end
      default: return PIX_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // size register value: mostly small, sometimes zero, sometimes a bit larger
  function automatic logic [CFG_BITS-1:0] pick_extent(int span);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_BITS'($urandom_range(span + 1, 2 * span));
      default: return CFG_BITS'($urandom_range(1, span));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: offer at the falling edge, hold valid until the transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && px_if.valid && px_if.ready) begin
      detect_peaks(px_if.pixel_value);
      void'(pixel_feed.pop_front());
      px_taken = 1'b1;
      feed_gap = next_gap(feed_calm);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      px_if.valid <= 1'b0;
    end else if (!px_if.valid || px_taken) begin
      px_taken = 1'b0;
      if (feed_gap > 0) begin
        feed_gap--;
        px_if.valid <= 1'b0;
      end else if (pixel_feed.size() != 0) begin
        px_if.valid       <= 1'b1;
        px_if.pixel_value <= pixel_feed[0];
      end else begin
        px_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // report receiver: random back-pressure, plus the long hold-off counted down here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      rpt_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      rpt_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      rpt_if.ready <= 1'b0;
    end else begin
      rpt_if.ready <= 1'b1;
      sink_stall = next_gap(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // report monitor: every transfer against the oldest expected report
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t want;
    if (rst_n && rpt_if.valid && rpt_if.ready) begin
      if (reports_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS) begin
          $display("unexpected report: kind %0d row %0d col %0d total %0d last %0d",
                   rpt_if.report_kind, rpt_if.peak_row, rpt_if.peak_col,
                   rpt_if.peak_total, rpt_if.last);
        end
      end else begin
        want = reports_due.pop_front();
        if (rpt_if.report_kind !== want.kind || rpt_if.peak_row !== want.row ||
            rpt_if.peak_col !== want.col || rpt_if.peak_total !== want.total ||
            rpt_if.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS) begin
            $display("report mismatch: expected kind %0d row %0d col %0d total %0d last %0d",
                     want.kind, want.row, want.col, want.total, want.last);
            $display("                 got      kind %0d row %0d col %0d total %0d last %0d",
                     rpt_if.report_kind, rpt_if.peak_row, rpt_if.peak_col,
                     rpt_if.peak_total, rpt_if.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer means a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((px_if.valid && px_if.ready) || (rpt_if.valid && rpt_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d reports outstanding",
                 quiet_cycles, reports_due.size());
        $display("tb_local_maximum_3x3_detector failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sender pauses until every report is back, then lets the pipeline settle
  task automatic wait_idle();
    do @(negedge clk); while (pixel_feed.size() != 0 || reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one register write; the predictor takes the new value at the transfer
  task automatic write_size(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = value;
    end else begin
      height_reg = value;
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_pixels(int count, pix_mix_t mix);
    @(posedge clk);
    repeat (count) pixel_feed.push_back(make_pixel(mix));
  endtask

  initial begin : stimulus
    int       fed, total, split, w;
    bit       pressed, big_done;
    pix_mix_t mix;

    rst_n            = 1'b0;
    px_if.valid      = 1'b0;
    px_if.pixel_value = '0;
    rpt_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_FRAME_WIDTH;
    cfg_if.wr_data   = '0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    sink_hold        = 0;
    pressed          = 1'b0;
    big_done         = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---

    // reset size is 1x1: every pixel is a lone peak plus a frame end
    @(posedge clk);
    pixel_feed.push_back({1'b0, {(PIX_W-1){1'b1}}});
    pixel_feed.push_back({1'b1, {(PIX_W-1){1'b0}}});
    wait_idle();

    // zero sizes act as one
    write_size(REG_FRAME_WIDTH, '0);
    write_size(REG_FRAME_HEIGHT, '0);
    @(posedge clk);
    pixel_feed.push_back('0);
    wait_idle();

    // flat 3x3 frame: equal neighbours never make a peak, frame end still comes
    write_size(REG_FRAME_WIDTH, CFG_BITS'(3));
    write_size(REG_FRAME_HEIGHT, CFG_BITS'(3));
    @(posedge clk);
    repeat (9) pixel_feed.push_back(PIX_W'(5));
    wait_idle();

    // oversize saturates to 1024x1024; a few pixels in, then both sizes shrink mid-frame
    write_size(REG_FRAME_WIDTH, '1);
    write_size(REG_FRAME_HEIGHT, '1);
    @(posedge clk);
    pixel_feed.push_back({1'b1, {(PIX_W-1){1'b0}}});
    pixel_feed.push_back({1'b0, {(PIX_W-1){1'b1}}});
    pixel_feed.push_back(PIX_W'(100));
    pixel_feed.push_back(PIX_W'(100));
    wait_idle();
    write_size(REG_FRAME_WIDTH, CFG_BITS'(2));
    write_size(REG_FRAME_HEIGHT, '0);
    queue_pixels(pixels_to_frame_end(), PIX_EDGES);
    wait_idle();

    // also reach the largest legal values exactly, then shrink again before any pixel
    write_size(REG_FRAME_WIDTH, CFG_BITS'(MAX_W));
    write_size(REG_FRAME_HEIGHT, CFG_BITS'(MAX_H));
    write_size(REG_FRAME_WIDTH, CFG_BITS'(4));
    write_size(REG_FRAME_HEIGHT, CFG_BITS'(3));
    queue_pixels(pixels_to_frame_end(), PIX_TIES);

    // --- random frames ---
    fed = 0;
    while (fed < RANDOM_PIXELS) begin
      mix = pix_mix_t'($urandom_range(0, 2));
      if (!pressed && fed >= 40) begin
        // receiver holds off while 1x1 frames keep coming: queue fills, input stalls
        wait_idle();
        write_size(REG_FRAME_WIDTH, CFG_BITS'(1));
        write_size(REG_FRAME_HEIGHT, CFG_BITS'(1));
        @(posedge clk);
        sink_hold = HOLD_CYCLES;
        queue_pixels(12, mix);
        wait (sink_hold == 0);
        fed += 12;
        pressed = 1'b1;
      end else if (!big_done && fed >= 120) begin
        // oversize width saturates to 1024 columns; a few pixels in, then it shrinks
        wait_idle();
        write_size(REG_FRAME_WIDTH, CFG_BITS'(MAX_W + 1));
        write_size(REG_FRAME_HEIGHT, CFG_BITS'(1));
        queue_pixels(6, PIX_WIDE);
        wait_idle();
        write_size(REG_FRAME_WIDTH, CFG_BITS'(8));
        total = pixels_to_frame_end();
        queue_pixels(total, PIX_WIDE);
        fed += 6 + total;
        big_done = 1'b1;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          wait_idle();
          write_size(REG_FRAME_WIDTH, pick_extent(8));
          write_size(REG_FRAME_HEIGHT, pick_extent(6));
        end
        total = frame_extent(width_reg, MAX_W) * frame_extent(height_reg, MAX_H);
        if (total > 1 && $urandom_range(0, 4) == 0) begin
          // stop part way, change a size while idle, then finish the frame
          split = $urandom_range(1, total - 1);
          queue_pixels(split, mix);
          wait_idle();
          w = frame_extent(width_reg, MAX_W);
          // width only shrinks mid-frame so no neighbour comes from an unwritten column
          if (w > 1 && $urandom_range(0, 1) == 1) begin
            write_size(REG_FRAME_WIDTH, CFG_BITS'($urandom_range(0, w - 1)));
          end else begin
            write_size(REG_FRAME_HEIGHT, CFG_BITS'($urandom_range(0, 8)));
          end
          total = pixels_to_frame_end();
          queue_pixels(total, mix);
          fed += split + total;
        end else begin
          queue_pixels(total, mix);
          fed += total;
        end
      end
    end

    // --- drain and verdict ---
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("tb_local_maximum_3x3_detector passed");
    end else begin
      $display("%0d mismatches, %0d reports never arrived", mismatch_count, reports_due.size());
      $display("tb_local_maximum_3x3_detector failed");
    end
    $finish;
  end

endmodule
